/* hdl/rmf_pkg.sv */
`timescale 1ns / 1ps
package rmf_pkg;
   localparam int MaxWidth = 4096;
   localparam int MaxHeight = 4096;
   localparam int PixW = 24;
   localparam int AddrW = $clog2(MaxWidth);
   localparam int CntW = $clog2(MaxHeight);
   localparam int CfgW = 13;

   typedef logic [PixW-1:0] pix_type;

   typedef struct packed {
      logic    emit_delay;
      logic    delay_median;
      logic    emit_rowend;
      logic    emit_own;
      logic [CntW-1:0] row;
      logic [AddrW-1:0] col;
      pix_type px;
   } cmd_type;

   localparam logic [0:0] RegWidth = 1'b0;
   localparam logic [0:0] RegHeight = 1'b1;

   function automatic logic [CfgW-1:0] clamp_size(input logic [CfgW-1:0] v,
                                                  input logic [CfgW-1:0] hi);
      logic [CfgW-1:0] r;
      r = v;
      if (v == '0) begin
         r = CfgW'(1);
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

   function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] r;
      if (((a >= b) && (a <= c)) || ((a <= b) && (a >= c))) r = a;
      else if (((b >= a) && (b <= c)) || ((b <= a) && (b >= c))) r = b;
      else r = c;
      return r;
   endfunction

   function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction
endpackage

/* hdl/rmf_ram.sv */
`timescale 1ns / 1ps
module rmf_ram #(
   parameter int Width = 24,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/rmf_front.sv */
`timescale 1ns / 1ps
module rmf_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rmf_pkg::CfgW-1:0]    width,
   input  logic [rmf_pkg::CfgW-1:0]    height,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_red,
   input  logic [7:0]                  req_green,
   input  logic [7:0]                  req_blue,
   output logic                        cmd_valid,
   input  logic                        cmd_ready,
   output rmf_pkg::cmd_type            cmd
);
   import rmf_pkg::*;

   logic [CntW-1:0] row_ff, row_in;
   logic [AddrW-1:0] col_ff, col_in;
   logic [CfgW-1:0] w, h;
   logic [CfgW-1:0] x, y;
   logic fire, row_end, last_row;

   assign w = clamp_size(width, CfgW'(MaxWidth));
   assign h = clamp_size(height, CfgW'(MaxHeight));
   assign x = CfgW'(col_ff);
   assign y = CfgW'(row_ff);
   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign fire = req_valid && cmd_ready;
   assign row_end = (x + CfgW'(1)) >= w;
   assign last_row = (y + CfgW'(1)) >= h;

   always_comb begin
      cmd.emit_delay = (y >= CfgW'(2)) && (x >= CfgW'(1));
      cmd.delay_median = (y + CfgW'(1) <= h) && (x + CfgW'(1) <= w) && (x >= CfgW'(2));
      cmd.emit_rowend = (y >= CfgW'(2)) && row_end;
      cmd.emit_own = (y == '0) || last_row;
      cmd.row = row_ff;
      cmd.col = col_ff;
      cmd.px = {req_blue, req_green, req_red};
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (fire) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + CntW'(1);
         end else begin
            col_in = col_ff + AddrW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   a_own_first_row: assert property (@(posedge clock) disable iff (reset)
      (fire && row_ff == '0) |-> cmd.emit_own) else $error("row 0 not copied");
   a_col_wrap: assert property (@(posedge clock) disable iff (reset)
      (fire && row_end) |=> col_ff == '0) else $error("column did not wrap");
   a_no_delay_early: assert property (@(posedge clock) disable iff (reset)
      (row_ff < CntW'(2)) |-> !cmd.emit_delay) else $error("early delayed output");
endmodule

/* hdl/rmf_back.sv */
`timescale 1ns / 1ps
module rmf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   output logic                     cmd_ready,
   input  rmf_pkg::cmd_type         cmd,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_out_red,
   output logic [7:0]               rsp_out_green,
   output logic [7:0]               rsp_out_blue,
   output logic [11:0]              rsp_out_row,
   output logic [11:0]              rsp_out_col,
   output logic                     rsp_last_of_run
);
   import rmf_pkg::*;

   // stage 1: queue slot + line store read
   logic s1_valid_ff, s1_valid_in;
   cmd_type s1_ff;
   pix_type p_rd, pp_rd;
   pix_type w0_ff, w1_ff, w2_ff, w3_ff, w4_ff, w5_ff;
   logic adv1, s2_free;
   logic byp_ff;
   pix_type byp_p_ff, byp_pp_ff, p_cur, pp_cur;

   // stage 2: window + median, then results held until sent
   logic s2_valid_ff;
   logic [2:0] s2_pend_ff;
   pix_type s2_med_ff, s2_copy_ff, s2_p_ff, s2_px_ff;
   logic [CntW-1:0] s2_row_ff;
   logic [AddrW-1:0] s2_col_ff;
   pix_type win [9];
   pix_type med;
   logic [2:0] pend_in;

   assign cmd_ready = !s1_valid_ff || adv1;
   assign s1_valid_in = cmd_valid || (s1_valid_ff && !adv1);

   rmf_ram #(.Width(PixW), .Depth(MaxWidth)) u_prev (
      .clock(clock), .wr_en(adv1), .wr_addr(s1_ff.col), .wr_data(s1_ff.px),
      .rd_en(cmd_valid && cmd_ready), .rd_addr(cmd.col), .rd_data(p_rd));
   rmf_ram #(.Width(PixW), .Depth(MaxWidth)) u_prev2 (
      .clock(clock), .wr_en(adv1), .wr_addr(s1_ff.col), .wr_data(p_cur),
      .rd_en(cmd_valid && cmd_ready), .rd_addr(cmd.col), .rd_data(pp_rd));

   // forward the entry written in the same cycle as the read of the same column
   assign p_cur = byp_ff ? byp_p_ff : p_rd;
   assign pp_cur = byp_ff ? byp_pp_ff : pp_rd;

   assign s2_free = !s2_valid_ff || (s2_pend_ff == 3'b000) ||
                    (rsp_ready && $countones(s2_pend_ff) == 1);
   assign adv1 = s1_valid_ff && s2_free;

   always_comb begin
      win[0] = w0_ff; win[3] = w1_ff; win[6] = w2_ff;
      win[1] = w3_ff; win[4] = w4_ff; win[7] = w5_ff;
      win[2] = pp_cur; win[5] = p_cur;  win[8] = s1_ff.px;
      for (int c = 0; c < 3; c++) begin
         logic [7:0] a [9];
         logic [7:0] mx, mn, md;
         for (int i = 0; i < 9; i++) a[i] = win[i][c*8 +: 8];
         mx = max3(min3(a[0], a[1], a[2]), min3(a[3], a[4], a[5]), min3(a[6], a[7], a[8]));
         mn = min3(max3(a[0], a[1], a[2]), max3(a[3], a[4], a[5]), max3(a[6], a[7], a[8]));
         md = med3(med3(a[0], a[1], a[2]), med3(a[3], a[4], a[5]), med3(a[6], a[7], a[8]));
         med[c*8 +: 8] = med3(mx, mn, md);
      end
   end

   always_comb begin
      pend_in = s2_pend_ff;
      if (s2_valid_ff && rsp_ready && s2_pend_ff != 3'b000) begin
         if (s2_pend_ff[0]) pend_in[0] = 1'b0;
         else if (s2_pend_ff[1]) pend_in[1] = 1'b0;
         else pend_in[2] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_pend_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (adv1) begin
            s2_valid_ff <= 1'b1;
            s2_pend_ff <= {s1_ff.emit_own, s1_ff.emit_rowend, s1_ff.emit_delay};
         end else begin
            s2_pend_ff <= pend_in;
         end
      end
      if (cmd_valid && cmd_ready) begin
         s1_ff <= cmd;
         byp_ff <= adv1 && (s1_ff.col == cmd.col);
         byp_p_ff <= s1_ff.px;
         byp_pp_ff <= p_cur;
      end
      if (adv1) begin
         w0_ff <= w3_ff; w1_ff <= w4_ff; w2_ff <= w5_ff;
         w3_ff <= pp_cur; w4_ff <= p_cur; w5_ff <= s1_ff.px;
         s2_med_ff <= med;
         s2_copy_ff <= w4_ff;
         s2_p_ff <= p_cur;
         s2_px_ff <= s1_ff.px;
         s2_row_ff <= s1_ff.row;
         s2_col_ff <= s1_ff.col;
         if (s1_ff.delay_median) begin
            s2_copy_ff <= med;
         end
      end
   end

   always_comb begin
      rsp_valid = s2_valid_ff && (s2_pend_ff != 3'b000);
      rsp_out_row = s2_row_ff;
      rsp_out_col = s2_col_ff;
      rsp_out_red = s2_px_ff[7:0];
      rsp_out_green = s2_px_ff[15:8];
      rsp_out_blue = s2_px_ff[23:16];
      if (s2_pend_ff[0]) begin
         rsp_out_row = s2_row_ff - CntW'(1);
         rsp_out_col = s2_col_ff - AddrW'(1);
         {rsp_out_blue, rsp_out_green, rsp_out_red} = s2_copy_ff;
      end else if (s2_pend_ff[1]) begin
         rsp_out_row = s2_row_ff - CntW'(1);
         {rsp_out_blue, rsp_out_green, rsp_out_red} = s2_p_ff;
      end
      rsp_last_of_run = $countones(s2_pend_ff) == 1;
   end

   a_pend_only_valid: assert property (@(posedge clock) disable iff (reset)
      !s2_valid_ff |-> s2_pend_ff == 3'b000) else $error("pending without data");
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(s2_pend_ff))
      else $error("result dropped");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> cmd_ready) else $error("queue empty but stalled");
endmodule

/* hdl/rgb_median_filter_3x3.sv */
`timescale 1ns / 1ps
// 3x3 per-channel median filter on an RGB raster stream. Pixels enter in raster order, one per
// clock while not stalled; row and column are counted inside. Interior pixels get the median
// of their nine neighbours, border pixels are copied. Each result carries its row and column.
// Output for pixel (y-1,x-1) leaves when (y,x) enters; a row end adds (y-1,width-1); rows 0
// and the last row also emit the pixel itself. One input transaction is taken per clock when
// the result side drains; an input that causes two or three results holds the input until
// the last of them is sent on the single result port. The first result of an input transaction
// is offered from an output register after one stage of line store read and median. The
// user must write sizes on the csr port only while idle; the block itself does not enforce it.
module rgb_median_filter_3x3 (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [0:0]                csr_index,
   input  logic [rmf_pkg::CfgW-1:0]  csr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_red,
   output logic [7:0]                rsp_out_green,
   output logic [7:0]                rsp_out_blue,
   output logic [11:0]               rsp_out_row,
   output logic [11:0]               rsp_out_col,
   output logic                      rsp_last_of_run
);
   import rmf_pkg::*;

   logic [CfgW-1:0] width_ff, height_ff;
   logic cmd_valid, cmd_ready;
   cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= CfgW'(640);
         height_ff <= CfgW'(480);
      end else if (csr_write) begin
         unique case (csr_index)
            RegWidth: width_ff <= csr_data;
            RegHeight: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   rmf_front u_front (
      .clock(clock), .reset(reset), .width(width_ff), .height(height_ff),
      .req_valid(req_valid), .req_ready(req_ready), .req_red(req_red),
      .req_green(req_green), .req_blue(req_blue),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

   rmf_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd(cmd), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_red(rsp_out_red), .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue), .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col), .rsp_last_of_run(rsp_last_of_run));
endmodule

/* tb/median_checker.sv */
`timescale 1ns / 1ps
module median_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_red,
   input  logic [7:0]  rsp_out_green,
   input  logic [7:0]  rsp_out_blue,
   input  logic [11:0] rsp_out_row,
   input  logic [11:0] rsp_out_col,
   input  logic        rsp_last_of_run,
   output int          fail_count,
   output int          pending_count
);
   import rmf_pkg::*;

   typedef struct packed {
      logic [23:0] px;
      logic [11:0] row;
      logic [11:0] col;
      logic        last;
   } pixel_out_t;

   logic [12:0] width_reg, height_reg;
   logic [23:0] line1 [MaxWidth];
   logic [23:0] line2 [MaxWidth];
   logic [23:0] win [6];
   int unsigned row_cnt, col_cnt;
   pixel_out_t expected_pixels [$];

   assign pending_count = expected_pixels.size();

   function automatic logic [7:0] median_of_nine(input logic [23:0] w [9], input int sh);
      logic [7:0] v [9];
      logic [7:0] t;
      for (int i = 0; i < 9; i++) v[i] = w[i][sh +: 8];
      for (int i = 0; i < 9; i++)
         for (int j = 0; j < 8 - i; j++)
            if (v[j] > v[j+1]) begin
               t = v[j]; v[j] = v[j+1]; v[j+1] = t;
            end
      return v[4];
   endfunction

   task automatic predict_pixel(input logic [23:0] px);
      int unsigned w, h, x, y, xi, n0;
      logic [23:0] pp, p, val;
      logic [23:0] nb [9];
      pixel_out_t e;
      w = (width_reg == 0) ? 1 : (width_reg > MaxWidth ? MaxWidth : width_reg);
      h = (height_reg == 0) ? 1 : (height_reg > MaxHeight ? MaxHeight : height_reg);
      x = col_cnt; y = row_cnt;
      xi = (x < MaxWidth) ? x : MaxWidth - 1;
      pp = line2[xi]; p = line1[xi];
      n0 = expected_pixels.size();
      if (y >= 2) begin
         if (x >= 1) begin
            if (y - 1 >= 1 && y + 1 <= h && x - 1 >= 1 && x + 1 <= w) begin
               for (int r = 0; r < 3; r++) begin
                  nb[r*3] = win[r]; nb[r*3+1] = win[3+r];
               end
               nb[2] = pp; nb[5] = p; nb[8] = px;
               val = {median_of_nine(nb, 16), median_of_nine(nb, 8), median_of_nine(nb, 0)};
            end else val = win[4];
            e.px = val; e.row = 12'(y - 1); e.col = 12'(x - 1); e.last = 0;
            expected_pixels.push_back(e);
         end
         if (x + 1 >= w) begin
            e.px = p; e.row = 12'(y - 1); e.col = 12'(x); e.last = 0;
            expected_pixels.push_back(e);
         end
      end
      if (y == 0 || y + 1 >= h) begin
         e.px = px; e.row = 12'(y); e.col = 12'(x); e.last = 0;
         expected_pixels.push_back(e);
      end
      if (expected_pixels.size() > n0) expected_pixels[$].last = 1;
      line2[xi] = p; line1[xi] = px;
      win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
      win[3] = pp; win[4] = p; win[5] = px;
      if (x + 1 >= w) begin
         col_cnt = 0;
         row_cnt = (y + 1 >= h) ? 0 : y + 1;
      end else col_cnt = x + 1;
   endtask

   always @(posedge clock) begin
      pixel_out_t e, got;
      if (reset) begin
         width_reg = 13'd640;
         height_reg = 13'd480;
         row_cnt = 0;
         col_cnt = 0;
         fail_count <= 0;
         expected_pixels.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == RegWidth) width_reg = csr_data;
            else height_reg = csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_blue, rsp_out_green, rsp_out_red, rsp_out_row, rsp_out_col,
                   rsp_last_of_run};
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_pixels.pop_front();
               if (got !== e) begin
                  $display("%0t: mismatch expected rgb=%h row=%0d col=%0d last=%b",
                           $time, e.px, e.row, e.col, e.last);
                  $display("%0t:          actual   rgb=%h row=%0d col=%0d last=%b",
                           $time, got.px, got.row, got.col, got.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_pixel({req_blue, req_green, req_red});
      end
   end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
   import rmf_pkg::*;

   logic clock = 0, reset = 1;
   logic csr_write = 0;
   logic [0:0] csr_index = RegWidth;
   logic [12:0] csr_data = '0;
   logic req_valid = 0, rsp_ready = 0;
   logic [7:0] req_red = 0, req_green = 0, req_blue = 0;
   logic req_ready, rsp_valid, rsp_last_of_run;
   logic [7:0] rsp_out_red, rsp_out_green, rsp_out_blue;
   logic [11:0] rsp_out_row, rsp_out_col;
   int fail_count, pending_count;
   int idle_cycles = 0;
   bit hold_off = 0;
   bit watchdog_armed = 1;

   always #5 clock = ~clock;

   rgb_median_filter_3x3 DUT (.*);
   median_checker checker_i (.*);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !watchdog_armed)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
               rsp_ready <= 0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_ready <= 1;
         @(negedge clock);
      end
   end

   task automatic write_size(input logic [0:0] idx, input logic [12:0] val);
      @(negedge clock);
      csr_write <= 1; csr_index <= idx; csr_data <= val;
      @(negedge clock);
      csr_write <= 0;
   endtask

   task automatic send_pixel(input logic [7:0] r, g, b, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 13) : 0;
      if (gaps && $urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1; req_red <= r; req_green <= g; req_blue <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      watchdog_armed = 1;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic send_frame(input int w, input int h, input int mode);
      logic [7:0] v;
      for (int i = 0; i < w * h; i++) begin
         v = 8'($urandom);
         case (mode)
            0: send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1);
            1: send_pixel((i % 2) ? 8'hff : 8'h00, (i % 3) ? 8'h00 : 8'hff, v, 1);
            default: send_pixel(v, v ^ 8'h5a, ~v, 0);
         endcase
      end
   endtask

   initial begin
      int w, h, count;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: extremes and small shapes
      write_size(RegWidth, 13'd3); write_size(RegHeight, 13'd3);
      send_frame(3, 3, 1);
      drain();
      write_size(RegWidth, 13'd1); write_size(RegHeight, 13'd1);
      send_pixel(8'hff, 8'hff, 8'hff, 0); send_pixel(8'h00, 8'h00, 8'h00, 0);
      drain();
      write_size(RegWidth, 13'd0); write_size(RegHeight, 13'd2);
      send_pixel(8'h12, 8'h34, 8'h56, 0); send_pixel(8'h80, 8'h7f, 8'h01, 0);
      drain();
      write_size(RegWidth, 13'd4); write_size(RegHeight, 13'd0);
      send_frame(4, 1, 1);
      drain();
      // back-pressure: sender keeps offering while the result side holds off
      write_size(RegWidth, 13'd5); write_size(RegHeight, 13'd5);
      hold_off = 1;
      send_frame(5, 5, 2);
      drain();
      // random frames
      count = 0;
      while (count < 420) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
         write_size(RegWidth, 13'(w)); write_size(RegHeight, 13'(h));
         send_frame(w, h, $urandom_range(0, 1));
         count += w * h;
         drain();
      end
      repeat (20) @(negedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
